@@ design/asps_pkg.sv @@
// ----------------------------------------------------------------------------
// asps_pkg
// Shared types and constants for the arm/spell/play sequencer: event and
// action codes, controller states, the queued action plan and register ids.
// ----------------------------------------------------------------------------
package asps_pkg;

  // default width of the kept word id
  localparam int WORD_BITS_DEF = 16;

  // fixed field widths
  localparam int TONE_W  = 8;
  localparam int WOUT_W  = 16;
  localparam int CFG_IW  = 2;

  // register reset values
  localparam logic [TONE_W-1:0] CONFIRM_RST  = 8'd0;
  localparam logic [TONE_W-1:0] RESOLVED_RST = 8'd1;
  localparam logic [TONE_W-1:0] ERROR_RST    = 8'd2;

  // register indexes
  localparam logic [CFG_IW-1:0] CFG_CONFIRM  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_RESOLVED = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_ERROR    = 2'd2;

  // input events
  typedef enum logic [2:0] {
    EV_PRESS     = 3'd0,
    EV_TIMEOUT   = 3'd1,
    EV_ONSET     = 3'd2,
    EV_EOW       = 3'd3,
    EV_RESOLVED  = 3'd4,
    EV_ABSTAIN   = 3'd5,
    EV_TONE_DONE = 3'd6,
    EV_PLAY_DONE = 3'd7
  } event_t;

  // result actions
  typedef enum logic [2:0] {
    ACT_TONE        = 3'd0,
    ACT_WORD        = 3'd1,
    ACT_CANCEL_PLAY = 3'd2,
    ACT_SEG         = 3'd3,
    ACT_START_TO    = 3'd4,
    ACT_CANCEL_TO   = 3'd5,
    ACT_NONE        = 3'd6
  } action_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_ARMED     = 3'd1,
    ST_SPELLING  = 3'd2,
    ST_RESOLVING = 3'd3,
    ST_PLAYING   = 3'd4
  } state_t;

  // tone registers as seen by the front
  typedef struct packed {
    logic [TONE_W-1:0] confirm;
    logic [TONE_W-1:0] resolved;
    logic [TONE_W-1:0] error;
  } tones_t;

  // one action result
  typedef struct packed {
    action_t           action;
    logic [TONE_W-1:0] tone;
    logic [WOUT_W-1:0] word;
    logic              seg;
  } act_t;

  // up to three actions of one event, plus the state after it
  typedef struct packed {
    act_t [2:0] acts;
    logic [1:0] count;
    state_t     new_state;
  } plan_t;

  // builds one action entry
  function automatic act_t mk_act(action_t a, logic [TONE_W-1:0] t,
                                  logic [WOUT_W-1:0] w, logic s);
    act_t r;
    r.action = a;
    r.tone   = t;
    r.word   = w;
    r.seg    = s;
    return r;
  endfunction

endpackage

@@ design/arm_spell_play_sequencer.sv @@
// ----------------------------------------------------------------------------
// arm_spell_play_sequencer
// Five-state press/spell/play controller with queued action results.
// ----------------------------------------------------------------------------
// Each event gives one to three action results, delivered one per cycle in
// order while the consumer pops; the result register drains at one result
// per cycle, so an event holds the back end until its results, three at most,
// are out. The front end takes a new event every cycle while its two-entry
// plan queue has room, so events may arrive back to back and results keep
// streaming while the consumer pops. The controller state and kept word id
// update on the cycle an event is accepted. Tone registers are written
// through cfg_we/cfg_index/cfg_data; an index past the last register is
// ignored.
module arm_spell_play_sequencer #(
  parameter int WORD_BITS = asps_pkg::WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  kind,
  input  logic [15:0] word_index,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  action,
  output logic [7:0]  tone_code,
  output logic [15:0] word_out,
  output logic        seg_enable,
  output logic [2:0]  new_state,
  output logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  asps_pkg::tones_t tones;
  asps_pkg::plan_t  plan;
  asps_pkg::plan_t  head;
  asps_pkg::act_t   res;
  asps_pkg::state_t res_state;
  logic             accept;
  logic             q_empty;
  logic             q_pop;

  assign accept = push && !full;

  // tone registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tones.confirm  <= asps_pkg::CONFIRM_RST;
      tones.resolved <= asps_pkg::RESOLVED_RST;
      tones.error    <= asps_pkg::ERROR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        asps_pkg::CFG_CONFIRM:  tones.confirm  <= cfg_data;
        asps_pkg::CFG_RESOLVED: tones.resolved <= cfg_data;
        asps_pkg::CFG_ERROR:    tones.error    <= cfg_data;
        default:                tones.confirm  <= tones.confirm;
      endcase
    end
  end

  asps_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (kind),
    .word_index(word_index),
    .tones     (tones),
    .plan      (plan)
  );

  asps_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (accept),
    .wr_plan(plan),
    .rd     (q_pop),
    .head   (head),
    .full   (full),
    .empty  (q_empty)
  );

  asps_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head     (head),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .res      (res),
    .res_state(res_state),
    .res_last (last)
  );

  // result fields
  assign action     = res.action;
  assign tone_code  = res.tone;
  assign word_out   = res.word;
  assign seg_enable = res.seg;
  assign new_state  = res_state;

endmodule

@@ design/asps_front.sv @@
// ----------------------------------------------------------------------------
// asps_front
// Event front end: holds the controller state and the kept word id, and
// turns each accepted event into an action plan for the back end.
// ----------------------------------------------------------------------------
module asps_front #(
  parameter int WORD_BITS = asps_pkg::WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [2:0]                   kind,
  input  logic [15:0]                  word_index,
  input  asps_pkg::tones_t             tones,
  output asps_pkg::plan_t              plan
);

  asps_pkg::state_t       mode;
  asps_pkg::state_t       mode_next;
  asps_pkg::event_t       ev;
  logic [WORD_BITS-1:0]   memo_word;
  logic                   memo_load;
  logic [47:0]            win_ext;
  logic [47:0]            memo_ext;
  logic [asps_pkg::WOUT_W-1:0] memo_view;
  asps_pkg::act_t         none_act;

  assign ev        = asps_pkg::event_t'(kind);
  assign win_ext   = 48'(word_index);
  assign memo_ext  = 48'(memo_word);
  assign memo_view = memo_ext[asps_pkg::WOUT_W-1:0];
  assign none_act  = asps_pkg::mk_act(asps_pkg::ACT_NONE, '0, '0, 1'b0);

  // next state
  always_comb begin
    mode_next = mode;
    case (mode)
      asps_pkg::ST_IDLE: begin
        if (ev == asps_pkg::EV_PRESS) mode_next = asps_pkg::ST_ARMED;
      end
      asps_pkg::ST_ARMED: begin
        if (ev == asps_pkg::EV_TIMEOUT) mode_next = asps_pkg::ST_IDLE;
        else if (ev == asps_pkg::EV_ONSET) mode_next = asps_pkg::ST_SPELLING;
      end
      asps_pkg::ST_SPELLING: begin
        if (ev == asps_pkg::EV_EOW || ev == asps_pkg::EV_RESOLVED)
          mode_next = asps_pkg::ST_RESOLVING;
        else if (ev == asps_pkg::EV_ABSTAIN) mode_next = asps_pkg::ST_IDLE;
      end
      asps_pkg::ST_RESOLVING: begin
        if (ev == asps_pkg::EV_ABSTAIN) mode_next = asps_pkg::ST_IDLE;
        else if (ev == asps_pkg::EV_TONE_DONE) mode_next = asps_pkg::ST_PLAYING;
      end
      asps_pkg::ST_PLAYING: begin
        if (ev == asps_pkg::EV_PRESS) mode_next = asps_pkg::ST_ARMED;
        else if (ev == asps_pkg::EV_PLAY_DONE) mode_next = asps_pkg::ST_IDLE;
      end
      default: mode_next = mode;
    endcase
  end

  // action plan for the event
  always_comb begin
    plan.acts      = {none_act, none_act, none_act};
    plan.count     = 2'd1;
    plan.new_state = mode_next;
    memo_load      = 1'b0;
    case (mode)
      asps_pkg::ST_IDLE: begin
        if (ev == asps_pkg::EV_PRESS) begin
          plan.acts[0] = asps_pkg::mk_act(asps_pkg::ACT_TONE, tones.confirm, '0, 1'b0);
          plan.acts[1] = asps_pkg::mk_act(asps_pkg::ACT_START_TO, '0, '0, 1'b0);
          plan.count   = 2'd2;
        end
      end
      asps_pkg::ST_ARMED: begin
        if (ev == asps_pkg::EV_TIMEOUT) begin
          plan.acts[0] = asps_pkg::mk_act(asps_pkg::ACT_SEG, '0, '0, 1'b0);
        end else if (ev == asps_pkg::EV_ONSET) begin
          plan.acts[0] = asps_pkg::mk_act(asps_pkg::ACT_CANCEL_TO, '0, '0, 1'b0);
        end else if (ev == asps_pkg::EV_TONE_DONE) begin
          plan.acts[0] = asps_pkg::mk_act(asps_pkg::ACT_SEG, '0, '0, 1'b1);
        end
      end
      asps_pkg::ST_SPELLING: begin
        if (ev == asps_pkg::EV_EOW) begin
          plan.acts[0] = asps_pkg::mk_act(asps_pkg::ACT_SEG, '0, '0, 1'b0);
        end else if (ev == asps_pkg::EV_RESOLVED) begin
          memo_load    = 1'b1;
          plan.acts[0] = asps_pkg::mk_act(asps_pkg::ACT_SEG, '0, '0, 1'b0);
          plan.acts[1] = asps_pkg::mk_act(asps_pkg::ACT_TONE, tones.resolved, '0, 1'b0);
          plan.count   = 2'd2;
        end else if (ev == asps_pkg::EV_ABSTAIN) begin
          plan.acts[0] = asps_pkg::mk_act(asps_pkg::ACT_SEG, '0, '0, 1'b0);
          plan.acts[1] = asps_pkg::mk_act(asps_pkg::ACT_TONE, tones.error, '0, 1'b0);
          plan.count   = 2'd2;
        end
      end
      asps_pkg::ST_RESOLVING: begin
        if (ev == asps_pkg::EV_RESOLVED) begin
          memo_load    = 1'b1;
          plan.acts[0] = asps_pkg::mk_act(asps_pkg::ACT_TONE, tones.resolved, '0, 1'b0);
        end else if (ev == asps_pkg::EV_ABSTAIN) begin
          plan.acts[0] = asps_pkg::mk_act(asps_pkg::ACT_TONE, tones.error, '0, 1'b0);
        end else if (ev == asps_pkg::EV_TONE_DONE) begin
          plan.acts[0] = asps_pkg::mk_act(asps_pkg::ACT_WORD, '0, memo_view, 1'b0);
        end
      end
      asps_pkg::ST_PLAYING: begin
        if (ev == asps_pkg::EV_PRESS) begin
          plan.acts[0] = asps_pkg::mk_act(asps_pkg::ACT_CANCEL_PLAY, '0, '0, 1'b0);
          plan.acts[1] = asps_pkg::mk_act(asps_pkg::ACT_TONE, tones.confirm, '0, 1'b0);
          plan.acts[2] = asps_pkg::mk_act(asps_pkg::ACT_START_TO, '0, '0, 1'b0);
          plan.count   = 2'd3;
        end
      end
      default: begin
        memo_load = 1'b0;
      end
    endcase
  end

  // state and kept word id
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= asps_pkg::ST_IDLE;
      memo_word <= '0;
    end else if (accept) begin
      mode <= mode_next;
      if (memo_load) memo_word <= win_ext[WORD_BITS-1:0];
    end
  end

endmodule

@@ design/asps_queue.sv @@
// ----------------------------------------------------------------------------
// asps_queue
// Two-entry plan queue between the front and the back end.
// ----------------------------------------------------------------------------
module asps_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  asps_pkg::plan_t wr_plan,
  input  logic            rd,
  output asps_pkg::plan_t head,
  output logic            full,
  output logic            empty
);

  asps_pkg::plan_t entry [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign head  = entry[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      if (wr && !rd) cnt <= cnt + 2'd1;
      else if (rd && !wr) cnt <= cnt - 2'd1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr) entry[wr_ptr] <= wr_plan;
  end

endmodule

@@ design/asps_back.sv @@
// ----------------------------------------------------------------------------
// asps_back
// Back end: steps through the head plan into a result register that the
// consumer pops, one action per cycle while that register is free or popped.
// ----------------------------------------------------------------------------
module asps_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  asps_pkg::plan_t head,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output asps_pkg::act_t  res,
  output asps_pkg::state_t res_state,
  output logic            res_last
);

  logic           out_valid;
  logic [1:0]     step;
  logic           load;
  logic           step_last;
  asps_pkg::act_t cur;

  assign empty     = ~out_valid;
  assign load      = !q_empty && (!out_valid || pop);
  assign step_last = (step == head.count - 2'd1);
  assign q_pop     = load && step_last;

  // select the action at the current step
  always_comb begin
    case (step)
      2'd0:    cur = head.acts[0];
      2'd1:    cur = head.acts[1];
      2'd2:    cur = head.acts[2];
      default: cur = head.acts[0];
    endcase
  end

  // step counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= step_last ? 2'd0 : step + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res       <= cur;
      res_state <= head.new_state;
      res_last  <= step_last;
    end
  end

endmodule

@@ design/asps_checker.sv @@
// ----------------------------------------------------------------------------
// asps_checker
// Port-level checks of the sequencer's result stream, bound to the top.
// ----------------------------------------------------------------------------
module asps_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [2:0] action,
  input logic [2:0] new_state,
  input logic       last
);

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // a full plan queue means the result register is already loaded
  a_full_has_result: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("plan queue full with no result shown");

  // results of one event follow without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last) |=> !empty)
    else $error("gap inside one event's results");

  // all results of one event carry the same state
  a_state_steady: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last) |=> (new_state == $past(new_state)))
    else $error("state changed within one event");

  // a none result is always alone
  a_none_alone: assert property (@(posedge clk) disable iff (rst)
    (!empty && action == asps_pkg::ACT_NONE) |-> last)
    else $error("none result not marked last");

endmodule

bind arm_spell_play_sequencer asps_checker u_asps_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .action   (action),
  .new_state(new_state),
  .last     (last)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the arm/spell/play sequencer. A behavioral copy of
// the controller predicts the ordered action items of every accepted event;
// a checker compares each popped item field by field against the oldest
// prediction. Directed walks cover stale events, all transitions but playing
// to idle, then state-aware random event streams run under several tone
// settings and idle patterns, with a long consumer stall that fills the block.
// ----------------------------------------------------------------------------
module tb_top;

  // index past the last tone register, must be ignored
  localparam logic [asps_pkg::CFG_IW-1:0] CFG_UNUSED = 2'd3;
  // cycles the block may still need after the last item drains
  localparam int SETTLE_CYCLES = 6;

  typedef struct {
    asps_pkg::action_t           action;
    logic [asps_pkg::TONE_W-1:0] tone;
    logic [asps_pkg::WOUT_W-1:0] word;
    logic                        seg;
    asps_pkg::state_t            nstate;
    logic                        last;
  } action_item_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [2:0]  kind;
  logic [15:0] word_index;
  logic        empty;
  logic        pop;
  logic [2:0]  action;
  logic [7:0]  tone_code;
  logic [15:0] word_out;
  logic        seg_enable;
  logic [2:0]  new_state;
  logic        last;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  // predicted controller state and tone registers
  asps_pkg::state_t            seq_mode;
  logic [15:0]                 memo_word;
  logic [asps_pkg::TONE_W-1:0] tone_confirm;
  logic [asps_pkg::TONE_W-1:0] tone_resolved;
  logic [asps_pkg::TONE_W-1:0] tone_error;

  action_item_t expected_actions[$];
  action_item_t step_actions[$];

  int errors;
  int events_sent;
  int actions_checked;
  int input_stalls;
  int snd_gap_pct;
  int rcv_gap_pct;
  int hold_left;

  arm_spell_play_sequencer u_top (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .word_index (word_index),
    .empty      (empty),
    .pop        (pop),
    .action     (action),
    .tone_code  (tone_code),
    .word_out   (word_out),
    .seg_enable (seg_enable),
    .new_state  (new_state),
    .last       (last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard run limit
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // consumer side: random pops, or a counted hold-off when requested
  always @(negedge clk) begin
    if (rst) begin
      pop = 1'b0;
    end else if (hold_left > 0) begin
      pop = 1'b0;
      hold_left--;
    end else begin
      pop = ($urandom_range(99) >= rcv_gap_pct);
    end
  end

  task automatic report_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("field %s: expected %0d, actual %0d", name, exp_v, got_v);
      errors++;
    end
  endtask

  // compare each popped item with the oldest prediction
  always @(posedge clk) begin
    action_item_t exp_item;
    if (!rst && pop && !empty) begin
      if (expected_actions.size() == 0) begin
        $error("unexpected item: action %0d state %0d", action, new_state);
        errors++;
      end else begin
        exp_item = expected_actions.pop_front();
        actions_checked++;
        report_field("action", 16'(exp_item.action), 16'(action));
        report_field("tone_code", 16'(exp_item.tone), 16'(tone_code));
        report_field("word_out", exp_item.word, word_out);
        report_field("seg_enable", 16'(exp_item.seg), 16'(seg_enable));
        report_field("new_state", 16'(exp_item.nstate), 16'(new_state));
        report_field("last", 16'(exp_item.last), 16'(last));
      end
    end
  end

  // append one action of the current event to the scratch list
  task automatic plan_action(input asps_pkg::action_t a,
                             input logic [asps_pkg::TONE_W-1:0] t,
                             input logic [15:0] w, input logic s);
    action_item_t it;
    it.action = a;
    it.tone   = t;
    it.word   = w;
    it.seg    = s;
    it.nstate = asps_pkg::ST_IDLE;
    it.last   = 1'b0;
    step_actions.push_back(it);
  endtask

  // predicted next state and action items for one accepted event
  task automatic advance_sequencer(input asps_pkg::event_t ev, input logic [15:0] w);
    asps_pkg::state_t nxt;
    action_item_t it;
    nxt = seq_mode;
    step_actions.delete();
    case (seq_mode)
      asps_pkg::ST_IDLE: begin
        if (ev == asps_pkg::EV_PRESS) begin
          nxt = asps_pkg::ST_ARMED;
          plan_action(asps_pkg::ACT_TONE, tone_confirm, 16'h0, 1'b0);
          plan_action(asps_pkg::ACT_START_TO, '0, 16'h0, 1'b0);
        end
      end
      asps_pkg::ST_ARMED: begin
        if (ev == asps_pkg::EV_TIMEOUT) begin
          nxt = asps_pkg::ST_IDLE;
          plan_action(asps_pkg::ACT_SEG, '0, 16'h0, 1'b0);
        end else if (ev == asps_pkg::EV_ONSET) begin
          nxt = asps_pkg::ST_SPELLING;
          plan_action(asps_pkg::ACT_CANCEL_TO, '0, 16'h0, 1'b0);
        end else if (ev == asps_pkg::EV_TONE_DONE) begin
          plan_action(asps_pkg::ACT_SEG, '0, 16'h0, 1'b1);
        end
      end
      asps_pkg::ST_SPELLING: begin
        if (ev == asps_pkg::EV_EOW) begin
          nxt = asps_pkg::ST_RESOLVING;
          plan_action(asps_pkg::ACT_SEG, '0, 16'h0, 1'b0);
        end else if (ev == asps_pkg::EV_RESOLVED) begin
          memo_word = w;
          nxt = asps_pkg::ST_RESOLVING;
          plan_action(asps_pkg::ACT_SEG, '0, 16'h0, 1'b0);
          plan_action(asps_pkg::ACT_TONE, tone_resolved, 16'h0, 1'b0);
        end else if (ev == asps_pkg::EV_ABSTAIN) begin
          nxt = asps_pkg::ST_IDLE;
          plan_action(asps_pkg::ACT_SEG, '0, 16'h0, 1'b0);
          plan_action(asps_pkg::ACT_TONE, tone_error, 16'h0, 1'b0);
        end
      end
      asps_pkg::ST_RESOLVING: begin
        if (ev == asps_pkg::EV_RESOLVED) begin
          memo_word = w;
          plan_action(asps_pkg::ACT_TONE, tone_resolved, 16'h0, 1'b0);
        end else if (ev == asps_pkg::EV_ABSTAIN) begin
          nxt = asps_pkg::ST_IDLE;
          plan_action(asps_pkg::ACT_TONE, tone_error, 16'h0, 1'b0);
        end else if (ev == asps_pkg::EV_TONE_DONE) begin
          nxt = asps_pkg::ST_PLAYING;
          plan_action(asps_pkg::ACT_WORD, '0, memo_word, 1'b0);
        end
      end
      asps_pkg::ST_PLAYING: begin
        if (ev == asps_pkg::EV_PRESS) begin
          nxt = asps_pkg::ST_ARMED;
          plan_action(asps_pkg::ACT_CANCEL_PLAY, '0, 16'h0, 1'b0);
          plan_action(asps_pkg::ACT_TONE, tone_confirm, 16'h0, 1'b0);
          plan_action(asps_pkg::ACT_START_TO, '0, 16'h0, 1'b0);
        end else if (ev == asps_pkg::EV_PLAY_DONE) begin
          nxt = asps_pkg::ST_IDLE;
        end
      end
      default: ;
    endcase
    // no action (stale event or play done): one none item carrying the next state
    if (step_actions.size() == 0) plan_action(asps_pkg::ACT_NONE, '0, 16'h0, 1'b0);
    seq_mode = nxt;
    foreach (step_actions[i]) begin
      it = step_actions[i];
      it.nstate = nxt;
      it.last = (i == step_actions.size() - 1);
      expected_actions.push_back(it);
    end
  endtask

  // offer one event and wait until it is taken
  task automatic send_item(input asps_pkg::event_t ev, input logic [15:0] w);
    while (snd_gap_pct > 0 && $urandom_range(99) < snd_gap_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    kind = ev;
    word_index = w;
    @(posedge clk);
    while (full) begin
      input_stalls++;
      @(posedge clk);
    end
    advance_sequencer(ev, w);
    events_sent++;
    @(negedge clk);
    push = 1'b0;
  endtask

  // hold the sender until every predicted item has been popped
  task automatic wait_for_drain();
    while (expected_actions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [asps_pkg::CFG_IW-1:0] idx,
                           input logic [7:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      asps_pkg::CFG_CONFIRM:  tone_confirm = val;
      asps_pkg::CFG_RESOLVED: tone_resolved = val;
      asps_pkg::CFG_ERROR:    tone_error = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // mostly events that the current state acts on, some noise
  function automatic asps_pkg::event_t pick_event(input asps_pkg::state_t s);
    int r;
    r = $urandom_range(2);
    if ($urandom_range(99) < 15) return asps_pkg::event_t'(3'($urandom_range(7)));
    case (s)
      asps_pkg::ST_IDLE: return asps_pkg::EV_PRESS;
      asps_pkg::ST_ARMED: begin
        if (r == 0) return asps_pkg::EV_TIMEOUT;
        else if (r == 1) return asps_pkg::EV_ONSET;
        else return asps_pkg::EV_TONE_DONE;
      end
      asps_pkg::ST_SPELLING: begin
        if (r == 0) return asps_pkg::EV_EOW;
        else if (r == 1) return asps_pkg::EV_RESOLVED;
        else return asps_pkg::EV_ABSTAIN;
      end
      asps_pkg::ST_RESOLVING: begin
        if (r == 0) return asps_pkg::EV_RESOLVED;
        else if (r == 1) return asps_pkg::EV_ABSTAIN;
        else return asps_pkg::EV_TONE_DONE;
      end
      asps_pkg::ST_PLAYING: begin
        if (r == 0) return asps_pkg::EV_PRESS;
        else return asps_pkg::EV_PLAY_DONE;
      end
      default: return asps_pkg::event_t'(3'($urandom_range(7)));
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // transitions except playing->idle, stale events in each state, word extremes
  task automatic test_directed();
    send_item(asps_pkg::EV_PRESS, 16'h0000);
    send_item(asps_pkg::EV_TONE_DONE, 16'hFFFF);
    send_item(asps_pkg::EV_EOW, 16'h1234);
    send_item(asps_pkg::EV_ONSET, 16'h0000);
    send_item(asps_pkg::EV_PRESS, 16'hFFFF);
    send_item(asps_pkg::EV_RESOLVED, 16'hFFFF);
    send_item(asps_pkg::EV_RESOLVED, 16'h0000);
    send_item(asps_pkg::EV_ONSET, 16'h5555);
    send_item(asps_pkg::EV_TONE_DONE, 16'hAAAA);
    send_item(asps_pkg::EV_TIMEOUT, 16'h0000);
    send_item(asps_pkg::EV_PRESS, 16'h0001);
    send_item(asps_pkg::EV_TIMEOUT, 16'h8000);
    send_item(asps_pkg::EV_PLAY_DONE, 16'h0000);
    send_item(asps_pkg::EV_PRESS, 16'h0000);
    send_item(asps_pkg::EV_ONSET, 16'h0000);
    send_item(asps_pkg::EV_EOW, 16'h0000);
    send_item(asps_pkg::EV_TONE_DONE, 16'h0000);
    send_item(asps_pkg::EV_PRESS, 16'h0000);
    send_item(asps_pkg::EV_ONSET, 16'h0000);
    send_item(asps_pkg::EV_ABSTAIN, 16'h0000);
    send_item(asps_pkg::EV_PRESS, 16'h0000);
    send_item(asps_pkg::EV_ONSET, 16'h0000);
    send_item(asps_pkg::EV_EOW, 16'h0000);
    send_item(asps_pkg::EV_ABSTAIN, 16'hFFFF);
    send_item(asps_pkg::EV_PLAY_DONE, 16'hFFFF);
  endtask

  // new tone settings once the block is quiet, plus an ignored index
  task automatic test_tone_settings(input logic [7:0] c, input logic [7:0] r,
                                    input logic [7:0] e);
    wait_for_drain();
    write_reg(asps_pkg::CFG_CONFIRM, c);
    write_reg(asps_pkg::CFG_RESOLVED, r);
    write_reg(asps_pkg::CFG_ERROR, e);
    write_reg(CFG_UNUSED, 8'($urandom));
  endtask

  task automatic test_random_events(input int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_for_drain();
      send_item(pick_event(seq_mode), pick_word());
    end
  endtask

  // consumer stalls long while the sender keeps offering
  task automatic test_backpressure(input int count);
    int saved_gap;
    saved_gap = snd_gap_pct;
    snd_gap_pct = 0;
    hold_left = 80;
    for (int i = 0; i < count; i++) send_item(pick_event(seq_mode), pick_word());
    snd_gap_pct = saved_gap;
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    kind = '0;
    word_index = '0;
    pop = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    events_sent = 0;
    actions_checked = 0;
    input_stalls = 0;
    hold_left = 0;
    seq_mode = asps_pkg::ST_IDLE;
    memo_word = '0;
    tone_confirm = asps_pkg::CONFIRM_RST;
    tone_resolved = asps_pkg::RESOLVED_RST;
    tone_error = asps_pkg::ERROR_RST;
    snd_gap_pct = 23;
    rcv_gap_pct = 53;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_tone_settings(8'hFF, 8'hFF, 8'hFF);
    test_random_events(140);

    test_tone_settings(8'h00, 8'h00, 8'h00);
    snd_gap_pct = 53;
    rcv_gap_pct = 23;
    test_random_events(140);
    test_backpressure(20);

    test_tone_settings(8'($urandom), 8'($urandom), 8'($urandom));
    snd_gap_pct = 0;
    rcv_gap_pct = 0;
    test_random_events(110);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("summary: %0d events sent, %0d action items checked", events_sent,
             actions_checked);
    $display("summary: %0d input stall cycles, %0d mismatches", input_stalls, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/asps_pkg.sv
design/asps_front.sv
design/asps_queue.sv
design/asps_back.sv
design/arm_spell_play_sequencer.sv
design/asps_checker.sv
verif/tb_top.sv
